// File: hdl/tcn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcn_pkg: shared types and constants for the tab column text normalizer
// Character codes, counter widths and the result entry layout.
// ----------------------------------------------------------------------------
package tcn_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned TabCntWidth = 4;
   localparam int unsigned FifoDepth  = 3;
   localparam int unsigned FifoCntWidth = 2;

   localparam logic [ByteWidth-1:0] ChrNewline = 8'd10;
   localparam logic [ByteWidth-1:0] ChrTab     = 8'd9;
   localparam logic [ByteWidth-1:0] ChrSpace   = 8'h20;
   localparam logic [ByteWidth-1:0] ChrHash    = 8'h23;
   localparam logic [ByteWidth-1:0] ChrUpperN  = 8'h4E;
   localparam logic [ByteWidth-1:0] ChrUpperU  = 8'h55;
   localparam logic [ByteWidth-1:0] ChrUpperA  = 8'h41;
   localparam logic [ByteWidth-1:0] ChrUpperZ  = 8'h5A;
   localparam logic [ByteWidth-1:0] CaseOffset = 8'h20;

   localparam logic [TabCntWidth-1:0] TabCntMax     = 4'd15;
   localparam logic [TabCntWidth-1:0] TabColGap     = 4'd4;
   localparam logic [TabCntWidth-1:0] TabColLinkA   = 4'd6;
   localparam logic [TabCntWidth-1:0] TabColLinkB   = 4'd7;
   localparam logic [TabCntWidth-1:0] TabColLimit   = 4'd8;
   localparam logic [TabCntWidth-1:0] TabColNinth   = 4'd9;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 last;
      logic                 spaces_seen;
      logic                 extra_tabs_seen;
      logic                 case_fixed;
   } rsp_entry_type;

endpackage

// File: hdl/tab_column_text_normalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_column_text_normalizer_unit: byte-stream tab column normalizer
// Drops leading spaces, turns spaces into tabs, collapses tab runs, handles
// comment and overflow pass-through and lowers case in gap line columns.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one text byte, or a line end marker, per request.
//   Response channel (rsp_*): zero, one or two bytes per request; rsp_last
//   marks the final byte of a request, and the three sticky flags give the
//   state after that request. A dropped byte produces no response.
//   Response bytes are registered in the output queue and leave it in order.
//   Throughput: one request per cycle while req_ready is high. Requests enter
//   a three-entry output queue; req_ready is high while two entries are free,
//   so a request that yields two bytes may hold off the next request.
//   req_ready does not depend on rsp_ready in the same cycle.
//   Stall: when rsp_ready is low the queue fills and req_ready drops; no data
//   is lost.
//   Reset (synchronous, active high): line state returns to start of line,
//   all sticky flags clear, the queue empties.
// ----------------------------------------------------------------------------
module tab_column_text_normalizer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcn_pkg::ByteWidth-1:0] req_text_byte,
   input  logic                          req_line_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcn_pkg::ByteWidth-1:0] rsp_out_byte,
   output logic                          rsp_last,
   output logic                          rsp_spaces_seen,
   output logic                          rsp_extra_tabs_seen,
   output logic                          rsp_case_fixed
);
   import tcn_pkg::*;

   // line state
   logic                   pass_through_ff, pass_through_in;
   logic [TabCntWidth-1:0] tab_count_ff, tab_count_in;
   logic                   prev_was_tab_ff, prev_was_tab_in;
   logic                   at_line_start_ff, at_line_start_in;
   logic                   gap_line_ff, gap_line_in;
   logic                   ninth_pend_ff, ninth_pend_in;
   logic                   space_flag_ff, space_flag_in;
   logic                   extra_flag_ff, extra_flag_in;
   logic                   case_flag_ff, case_flag_in;

   // output queue, entry 0 is the head
   rsp_entry_type           fifo_ff [FifoDepth];
   rsp_entry_type           fifo_in [FifoDepth];
   logic [FifoCntWidth-1:0] cnt_ff, cnt_in;

   logic                 req_fire;
   logic                 rsp_fire;
   logic [1:0]           n_res;
   logic [ByteWidth-1:0] res0_byte;
   logic [ByteWidth-1:0] res1_byte;
   logic [FifoCntWidth-1:0] base;

   assign req_ready = (cnt_ff <= FifoCntWidth'(1));
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_fire  = rsp_valid & rsp_ready;

   assign rsp_out_byte        = fifo_ff[0].out_byte;
   assign rsp_last            = fifo_ff[0].last;
   assign rsp_spaces_seen     = fifo_ff[0].spaces_seen;
   assign rsp_extra_tabs_seen = fifo_ff[0].extra_tabs_seen;
   assign rsp_case_fixed      = fifo_ff[0].case_fixed;

   // per-byte decision
   always_comb begin
      logic [ByteWidth-1:0] ch;
      logic                 is_space;
      logic                 is_tab;
      ch               = req_text_byte;
      is_space         = (req_text_byte == ChrSpace);
      is_tab           = (req_text_byte == ChrTab);
      pass_through_in  = pass_through_ff;
      tab_count_in     = tab_count_ff;
      prev_was_tab_in  = prev_was_tab_ff;
      at_line_start_in = at_line_start_ff;
      gap_line_in      = gap_line_ff;
      ninth_pend_in    = ninth_pend_ff;
      space_flag_in    = space_flag_ff;
      extra_flag_in    = extra_flag_ff;
      case_flag_in     = case_flag_ff;
      n_res            = 2'd0;
      res0_byte        = req_text_byte;
      res1_byte        = req_text_byte;

      if (req_line_end) begin
         if (ninth_pend_ff) extra_flag_in = 1'b1;
         ninth_pend_in    = 1'b0;
         pass_through_in  = 1'b0;
         tab_count_in     = '0;
         prev_was_tab_in  = 1'b0;
         at_line_start_in = 1'b1;
         gap_line_in      = 1'b0;
         res0_byte        = ChrNewline;
         n_res            = 2'd1;
      end else begin
         if (ninth_pend_ff) begin
            if (ch != ChrHash) extra_flag_in = 1'b1;
            ninth_pend_in = 1'b0;
         end
         priority if (pass_through_ff) begin
            n_res = 2'd1;
         end else if (is_space && at_line_start_ff) begin
            n_res = 2'd0;
         end else if (is_space || is_tab) begin
            if (is_space) space_flag_in = 1'b1;
            if (prev_was_tab_ff) begin
               // collapsed into the previous tab
               if (!space_flag_in) extra_flag_in = 1'b1;
            end else begin
               if (tab_count_ff != TabCntMax) tab_count_in = tab_count_ff + 1'b1;
               prev_was_tab_in = 1'b1;
               if (tab_count_in > TabColLimit && !space_flag_in) begin
                  if (tab_count_in == TabColNinth) ninth_pend_in = 1'b1;
                  else                             extra_flag_in = 1'b1;
               end
               res0_byte = ChrTab;
               n_res     = 2'd1;
            end
         end else if (ch == ChrHash) begin
            pass_through_in = 1'b1;
            n_res           = 2'd1;
         end else begin
            if (prev_was_tab_ff && tab_count_ff == TabColGap)
               gap_line_in = (ch == ChrUpperN) || (ch == ChrUpperU);
            if (tab_count_ff > TabColLimit) begin
               pass_through_in = 1'b1;
               res0_byte       = ChrTab;
               res1_byte       = ch;
               n_res           = 2'd2;
            end else begin
               if (gap_line_in
                   && (tab_count_ff == TabColLinkA || tab_count_ff == TabColLinkB)
                   && ch >= ChrUpperA && ch <= ChrUpperZ) begin
                  res0_byte    = ch + CaseOffset;
                  case_flag_in = 1'b1;
               end
               at_line_start_in = 1'b0;
               prev_was_tab_in  = 1'b0;
               n_res            = 2'd1;
            end
         end
      end
   end

   // queue update: pop shifts down, new bytes land after the survivors
   always_comb begin
      rsp_entry_type e0;
      rsp_entry_type e1;
      e0.out_byte        = res0_byte;
      e0.last            = (n_res == 2'd1);
      e0.spaces_seen     = space_flag_in;
      e0.extra_tabs_seen = extra_flag_in;
      e0.case_fixed      = case_flag_in;
      e1                 = e0;
      e1.out_byte        = res1_byte;
      e1.last            = 1'b1;
      base = cnt_ff - FifoCntWidth'(rsp_fire);
      for (int i = 0; i < FifoDepth; i++) begin
         if (rsp_fire && i < FifoDepth - 1) fifo_in[i] = fifo_ff[i+1];
         else                               fifo_in[i] = fifo_ff[i];
         if (req_fire && n_res != 2'd0 && FifoCntWidth'(i) == base)
            fifo_in[i] = e0;
         if (req_fire && n_res == 2'd2 && FifoCntWidth'(i) == base + 1'b1)
            fifo_in[i] = e1;
      end
      cnt_in = base + (req_fire ? FifoCntWidth'(n_res) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_through_ff  <= 1'b0;
         tab_count_ff     <= '0;
         prev_was_tab_ff  <= 1'b0;
         at_line_start_ff <= 1'b1;
         gap_line_ff      <= 1'b0;
         ninth_pend_ff    <= 1'b0;
         space_flag_ff    <= 1'b0;
         extra_flag_ff    <= 1'b0;
         case_flag_ff     <= 1'b0;
         cnt_ff           <= '0;
      end else begin
         if (req_fire) begin
            pass_through_ff  <= pass_through_in;
            tab_count_ff     <= tab_count_in;
            prev_was_tab_ff  <= prev_was_tab_in;
            at_line_start_ff <= at_line_start_in;
            gap_line_ff      <= gap_line_in;
            ninth_pend_ff    <= ninth_pend_in;
            space_flag_ff    <= space_flag_in;
            extra_flag_ff    <= extra_flag_in;
            case_flag_ff     <= case_flag_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FifoDepth; i++) fifo_ff[i] <= fifo_in[i];
   end

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FifoCntWidth'(FifoDepth))
      else $error("output queue count beyond depth");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_line_end |=> tab_count_ff == '0 && at_line_start_ff && !pass_through_ff)
      else $error("line end did not clear line state");

   a_pass_no_pend: assert property (@(posedge clock) disable iff (reset)
      pass_through_ff |-> !ninth_pend_ff)
      else $error("ninth tab pending during pass-through");

   a_prev_tab_count: assert property (@(posedge clock) disable iff (reset)
      prev_was_tab_ff |-> tab_count_ff != '0)
      else $error("tab seen with zero tab count");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(space_flag_ff) && !$fell(extra_flag_ff) && !$fell(case_flag_ff))
      else $error("sticky flag cleared");

endmodule
